/* hdl/oblt_pkg.sv */
package oblt_pkg;

   localparam int DefLevels    = 64;
   localparam int DefPriceBits = 32;

   typedef enum logic [1:0] {
      ACT_CLEAR    = 2'd0,
      ACT_SNAPSHOT = 2'd1,
      ACT_UPDATE   = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        side;
      logic [31:0] price;
      logic [30:0] quantity;
      logic [63:0] timestamp;
      logic        end_of_message;
   } req_type;

   typedef struct packed {
      logic [63:0] stamp;
      logic [31:0] bid_price;
      logic [30:0] bid_quantity;
      logic        bid_present;
      logic [31:0] ask_price;
      logic [30:0] ask_quantity;
      logic        ask_present;
      logic        overflow;
   } rsp_type;

   // command from the side controller to every cell in one chain
   typedef struct packed {
      logic        clear;
      logic        set;
      logic        erase;
      logic [63:0] price;
      logic [30:0] qty;
   } cmd_type;

endpackage

/* hdl/oblt_cell.sv */
// One sorted slot. Cells hold prices in best-first order from index 0; a
// cell sees its better neighbor (prev) and worse neighbor (next) and picks
// hold, shift to worse (insert), shift to better (delete), load or clear.
module oblt_cell #(
   parameter int PRICE_BITS = oblt_pkg::DefPriceBits
) (
   input  logic                    clock,
   input  logic                    reset,
   input  oblt_pkg::cmd_type       cmd,
   input  logic                    want_high,
   input  logic                    prev_used,
   input  logic [PRICE_BITS-1:0]   prev_price,
   input  logic [30:0]             prev_qty,
   input  logic                    prev_ahead,
   input  logic                    prev_match,
   input  logic                    next_used,
   input  logic [PRICE_BITS-1:0]   next_price,
   input  logic [30:0]             next_qty,
   input  logic                    chain_full,
   input  logic                    any_match,
   output logic                    used,
   output logic [PRICE_BITS-1:0]   price,
   output logic [30:0]             qty,
   output logic                    ahead,
   output logic                    match
);
   import oblt_pkg::*;

   logic                  used_ff, used_in;
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [30:0]           qty_ff, qty_in;
   logic [PRICE_BITS-1:0] cp;

   assign cp = cmd.price[PRICE_BITS-1:0];
   assign match = used_ff && (price_ff == cp);
   // "ahead": this cell stays ahead of the new price
   assign ahead = used_ff &&
                  (want_high ? (price_ff > cp) : (price_ff < cp));

   always_comb begin
      used_in  = used_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      if (cmd.clear) begin
         used_in = 1'b0;
      end else if (cmd.set && any_match) begin
         if (match) qty_in = cmd.qty;
      end else if (cmd.set && !chain_full) begin
         if (!ahead) begin
            if (prev_ahead) begin
               used_in  = 1'b1;
               price_in = cp;
               qty_in   = cmd.qty;
            end else begin
               used_in  = prev_used;
               price_in = prev_price;
               qty_in   = prev_qty;
            end
         end
      end else if (cmd.erase && any_match) begin
         if (match || prev_match) begin
            used_in  = next_used;
            price_in = next_price;
            qty_in   = next_qty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end

   assign used  = used_ff;
   assign price = price_ff;
   assign qty   = qty_ff;
endmodule

/* hdl/oblt_side.sv */
module oblt_side #(
   parameter int LEVELS     = oblt_pkg::DefLevels,
   parameter int PRICE_BITS = oblt_pkg::DefPriceBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  want_high,
   input  oblt_pkg::cmd_type     cmd,
   output logic                  full_drop,
   output logic                  best_used,
   output logic [PRICE_BITS-1:0] best_price,
   output logic [30:0]           best_qty
);
   import oblt_pkg::*;

   logic                  used   [LEVELS];
   logic [PRICE_BITS-1:0] price  [LEVELS];
   logic [30:0]           qty    [LEVELS];
   logic [LEVELS-1:0]     ahead;
   logic [LEVELS-1:0]     match;
   logic                  any_match;

   assign any_match = |match;
   assign full_drop = cmd.set && !any_match && used[LEVELS-1];

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      logic                  pu, pb, pm, nu;
      logic [PRICE_BITS-1:0] pp, np;
      logic [30:0]           pq, nq;
      if (i == 0) begin : g_first
         assign pu = 1'b0;
         assign pp = '0;
         assign pq = '0;
         assign pb = 1'b1;
         assign pm = 1'b0;
      end else begin : g_mid
         assign pu = used[i-1];
         assign pp = price[i-1];
         assign pq = qty[i-1];
         assign pb = ahead[i-1];
         assign pm = |match[i-1:0];
      end
      if (i == LEVELS-1) begin : g_last
         assign nu = 1'b0;
         assign np = '0;
         assign nq = '0;
      end else begin : g_inner
         assign nu = used[i+1];
         assign np = price[i+1];
         assign nq = qty[i+1];
      end
      oblt_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
         .clock, .reset, .cmd, .want_high,
         .prev_used(pu), .prev_price(pp), .prev_qty(pq),
         .prev_ahead(pb), .prev_match(pm),
         .next_used(nu), .next_price(np), .next_qty(nq),
         .chain_full(used[LEVELS-1]), .any_match,
         .used(used[i]), .price(price[i]), .qty(qty[i]),
         .ahead(ahead[i]), .match(match[i])
      );
   end

   assign best_used  = used[0];
   assign best_price = used[0] ? price[0] : '0;
   assign best_qty   = used[0] ? qty[0] : '0;

   assert property (@(posedge clock) disable iff (reset)
      (cmd.clear && !cmd.set) |=> !best_used)
      else $error("side not empty after clear");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("price held twice");
   assert property (@(posedge clock) disable iff (reset)
      (used[1] && used[0]) |-> (want_high ? price[0] > price[1] : price[0] < price[1]))
      else $error("head out of order");
endmodule

/* hdl/order_book_level_table.sv */
// Two sorted chains of LEVELS cells (asks lowest first, bids highest first).
// Each beat goes to the cells at once, busy is never raised, so a beat may be
// started every cycle. A message's result appears on rsp_* with rsp_valid
// for exactly one cycle, the cycle after the end_of_message beat, and the
// receiver cannot stall it. A new price on a full side is dropped and sets
// the sticky overflow flag, cleared only by reset.
module order_book_level_table #(
   parameter int LEVELS     = oblt_pkg::DefLevels,
   parameter int PRICE_BITS = oblt_pkg::DefPriceBits
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  oblt_pkg::req_type req_data,
   output logic              rsp_valid,
   output oblt_pkg::rsp_type rsp_data
);
   import oblt_pkg::*;

   logic                  acc;
   cmd_type               cmd_a, cmd_b, cmd;
   logic                  drop_a, drop_b;
   logic                  au, bu;
   logic [PRICE_BITS-1:0] ap, bp;
   logic [30:0]           aq, bq;
   logic                  ovf_ff, ovf_in;
   logic                  pend_ff, pend_in;
   logic [63:0]           stamp_ff, stamp_in;

   assign busy = 1'b0;
   assign acc  = start && !busy;

   always_comb begin
      cmd       = '0;
      cmd.price = 64'(req_data.price[PRICE_BITS > 32 ? 31 : PRICE_BITS-1:0]);
      cmd.qty   = req_data.quantity;
      if (acc) begin
         unique case (action_type'(req_data.action))
            ACT_CLEAR:    cmd.clear = 1'b1;
            ACT_SNAPSHOT: cmd.set   = req_data.quantity != '0;
            ACT_UPDATE: begin
               cmd.set   = req_data.quantity != '0;
               cmd.erase = req_data.quantity == '0;
            end
            default: ;
         endcase
      end
      cmd_a = cmd;
      cmd_b = cmd;
      cmd_a.set   = cmd.set   && !req_data.side;
      cmd_a.erase = cmd.erase && !req_data.side;
      cmd_b.set   = cmd.set   && req_data.side;
      cmd_b.erase = cmd.erase && req_data.side;
   end

   oblt_side #(.LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS)) u_ask (
      .clock, .reset, .want_high(1'b0), .cmd(cmd_a), .full_drop(drop_a),
      .best_used(au), .best_price(ap), .best_qty(aq)
   );
   oblt_side #(.LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS)) u_bid (
      .clock, .reset, .want_high(1'b1), .cmd(cmd_b), .full_drop(drop_b),
      .best_used(bu), .best_price(bp), .best_qty(bq)
   );

   assign ovf_in   = ovf_ff || drop_a || drop_b;
   assign pend_in  = acc && req_data.end_of_message;
   assign stamp_in = acc ? req_data.timestamp : stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         stamp_ff <= '0;
      end else begin
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
         stamp_ff <= stamp_in;
      end
   end

   assign rsp_valid             = pend_ff;
   assign rsp_data.stamp        = stamp_ff;
   assign rsp_data.bid_price    = 32'(bp);
   assign rsp_data.bid_quantity = bq;
   assign rsp_data.bid_present  = bu;
   assign rsp_data.ask_price    = 32'(ap);
   assign rsp_data.ask_quantity = aq;
   assign rsp_data.ask_present  = au;
   assign rsp_data.overflow     = ovf_ff;

   assert property (@(posedge clock) disable iff (reset)
      $past(ovf_ff) |-> ovf_ff)
      else $error("overflow not sticky");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && req_data.end_of_message))
      else $error("spurious result");
   assert property (@(posedge clock) disable iff (reset)
      !(drop_a && drop_b))
      else $error("both sides written");
endmodule
